// ===== rtl/three_wire_register_bus_master_unit_macros.svh =====
// assertion macros for the three-wire register bus master
`ifndef THREE_WIRE_REGISTER_BUS_MASTER_UNIT_MACROS_SVH
`define THREE_WIRE_REGISTER_BUS_MASTER_UNIT_MACROS_SVH

// antecedent in a cycle requires consequent in the same cycle
`define TWRBM_ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("three-wire master: implication check failed");

// condition must never be seen
`define TWRBM_ASSERT_NEVER(label, clk_s, rstn_s, cond) \
    label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) !(cond)) \
        else $error("three-wire master: forbidden condition seen");

`endif

// ===== rtl/twrbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twrbm_pkg
// shared types and constants of the three-wire register bus master
// ----------------------------------------------------------------------------
package twrbm_pkg;

    localparam int PHASE_W       = 7;
    localparam int ADDR_BITS_DEF = 7;
    localparam int DATA_BITS_DEF = 16;
    localparam int PRE_LEN       = 6;
    localparam int ADDR_W        = 7;
    localparam int WORD_W        = 16;

    localparam logic [1:0] MODE_DELAY = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // extra periods spent in the first read phase
    localparam logic [1:0] READ_HOLD  = 2'd2;

    typedef struct packed {
        logic       clk;
        logic       en;
        logic       drv;
        logic       set_data;
        logic       data;
        logic [1:0] hold;
        logic       sample;
    } phase_t;

endpackage
`default_nettype wire

// ===== rtl/three_wire_register_bus_master_unit.sv =====
// path: a request goes from the input register into the result register unless stalled
// throughput: one request per cycle unless stalled, each a delay period or a start command
// the phase decode and the pin update sit between input register and pin registers
// reset: asynchronous, pins go to enable high, clock low, driving zero, no frame active
`timescale 1ns / 1ps
`default_nettype none
`include "three_wire_register_bus_master_unit_macros.svh"
// ----------------------------------------------------------------------------
// three_wire_register_bus_master_unit
// master for a three-wire register bus (clock, bidirectional data, enable),
// stepping through the phases of write and read frames one request at a time
// ----------------------------------------------------------------------------
module three_wire_register_bus_master_unit #(
    parameter int ADDR_BITS = twrbm_pkg::ADDR_BITS_DEF,
    parameter int DATA_BITS = twrbm_pkg::DATA_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      mode,
    input  wire logic [twrbm_pkg::ADDR_W-1:0]    reg_address,
    input  wire logic [twrbm_pkg::WORD_W-1:0]    write_word,
    input  wire logic                            data_line_in,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 clock_pin,
    output logic                                 data_pin_out,
    output logic                                 data_drive,
    output logic                                 enable_pin,
    output logic                                 busy_res,
    output logic [twrbm_pkg::WORD_W-1:0]         read_word,
    output logic                                 read_done
);

    localparam int PW = twrbm_pkg::PHASE_W;
    localparam logic [PW-1:0] PRE_LEN  = PW'(twrbm_pkg::PRE_LEN);
    localparam logic [PW-1:0] ADDR_PH  = PW'(2 * ADDR_BITS);
    localparam logic [PW-1:0] DATA_PH  = PW'(2 * DATA_BITS);
    localparam logic [PW-1:0] WR_LEN   = PW'(8 + 2 * ADDR_BITS + 2 * DATA_BITS);
    localparam logic [PW-1:0] RD_LEN   = PW'(11 + 2 * ADDR_BITS + 2 * DATA_BITS);

    // input register
    logic                                in_valid_reg;
    logic [1:0]                          mode_reg;
    logic [twrbm_pkg::ADDR_W-1:0]        address_in_reg;
    logic [twrbm_pkg::WORD_W-1:0]        word_in_reg;
    logic                                line_in_reg;

    // frame state
    logic                                frame_active_reg, frame_active_next;
    logic                                frame_is_read_reg, frame_is_read_next;
    logic [PW-1:0]                       phase_reg, phase_next;
    logic [1:0]                          hold_count_reg, hold_count_next;
    logic [ADDR_BITS-1:0]                address_shift_reg, address_shift_next;
    logic [DATA_BITS-1:0]                word_shift_reg, word_shift_next;
    logic [DATA_BITS-1:0]                captured_reg, captured_next;
    logic                                clk_pin_reg, clk_pin_next;
    logic                                dat_pin_reg, dat_pin_next;
    logic                                drv_pin_reg, drv_pin_next;
    logic                                en_pin_reg, en_pin_next;
    logic                                done_reg, done_next;
    logic                                out_valid_reg;

    logic                                out_free;
    logic                                fire;
    logic                                apply;
    logic [PW-1:0]                       apply_phase;
    logic [PW-1:0]                       phase_inc;
    twrbm_pkg::phase_t                   cur_ph;
    twrbm_pkg::phase_t                   new_ph;

    function automatic twrbm_pkg::phase_t describe(
        input logic                 is_read,
        input logic [PW-1:0]        p,
        input logic [ADDR_BITS-1:0] addr,
        input logic [DATA_BITS-1:0] word
    );
        twrbm_pkg::phase_t    ph;
        logic [PW-1:0]        k;
        logic [PW-1:0]        ka;
        logic [PW-1:0]        kr;
        logic [ADDR_BITS-1:0] addr_sh;
        logic [DATA_BITS-1:0] word_sh;
        ph      = '0;
        k       = p - PRE_LEN;
        ka      = k - ADDR_PH;
        kr      = ka - PW'(3);
        addr_sh = addr << k[PW-1:1];
        word_sh = word << ka[PW-1:1];
        if (p < PRE_LEN)
        begin
            ph.clk = p[0];
            ph.en  = (p < PW'(2));
            if (is_read)
            begin
                ph.drv = (p >= PW'(4));
                if (p == '0)
                begin
                    ph.hold = twrbm_pkg::READ_HOLD;
                end
                if (p == PW'(4))
                begin
                    ph.set_data = 1'b1;
                    ph.data     = 1'b1;
                end
            end
            else
            begin
                ph.drv = 1'b1;
                if (p == PW'(2) || p == PW'(3))
                begin
                    ph.set_data = 1'b1;
                    ph.data     = 1'b1;
                end
                if (p == PW'(4))
                begin
                    ph.set_data = 1'b1;
                end
            end
        end
        else if (k < ADDR_PH)
        begin
            // address bits msb first
            ph.clk      = k[0];
            ph.drv      = 1'b1;
            ph.set_data = 1'b1;
            ph.data     = addr_sh[ADDR_BITS-1];
        end
        else if (!is_read)
        begin
            ph.clk = ka[0];
            ph.drv = 1'b1;
            if (ka < DATA_PH)
            begin
                ph.set_data = 1'b1;
                ph.data     = word_sh[DATA_BITS-1];
            end
            else
            begin
                ph.en = 1'b1;
            end
        end
        else if (ka < PW'(3))
        begin
            // dummy clock with the line released
            ph.clk = ka[0];
        end
        else
        begin
            // sample on the high phases, then close with enable low
            ph.clk    = ~kr[0];
            ph.sample = ~kr[0] & (kr < DATA_PH);
        end
        return ph;
    endfunction

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !out_free;
    assign fire     = in_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg       <= mode;
            address_in_reg <= reg_address;
            word_in_reg    <= write_word;
            line_in_reg    <= data_line_in;
        end
    end

    assign phase_inc = phase_reg + PW'(1);
    assign cur_ph    = describe(frame_is_read_reg, phase_reg, address_shift_reg, word_shift_reg);

    always_comb
    begin
        frame_active_next  = frame_active_reg;
        frame_is_read_next = frame_is_read_reg;
        phase_next         = phase_reg;
        hold_count_next    = hold_count_reg;
        address_shift_next = address_shift_reg;
        word_shift_next    = word_shift_reg;
        captured_next      = captured_reg;
        clk_pin_next       = clk_pin_reg;
        dat_pin_next       = dat_pin_reg;
        drv_pin_next       = drv_pin_reg;
        en_pin_next        = en_pin_reg;
        done_next          = 1'b0;
        apply              = 1'b0;
        apply_phase        = '0;
        if (!frame_active_reg)
        begin
            unique case (mode_reg) inside
                twrbm_pkg::MODE_WRITE, twrbm_pkg::MODE_READ:
                begin
                    frame_active_next  = 1'b1;
                    frame_is_read_next = (mode_reg == twrbm_pkg::MODE_READ);
                    phase_next         = '0;
                    address_shift_next = ADDR_BITS'(address_in_reg);
                    word_shift_next    = (mode_reg == twrbm_pkg::MODE_READ) ? '0
                                         : DATA_BITS'(word_in_reg);
                    apply              = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (mode_reg == twrbm_pkg::MODE_DELAY)
        begin
            if (hold_count_reg != 2'd0)
            begin
                hold_count_next = hold_count_reg - 2'd1;
            end
            else
            begin
                if (cur_ph.sample)
                begin
                    word_shift_next = {word_shift_reg[DATA_BITS-2:0], line_in_reg};
                end
                if (phase_inc >= (frame_is_read_reg ? RD_LEN : WR_LEN))
                begin
                    frame_active_next = 1'b0;
                    phase_next        = '0;
                    hold_count_next   = 2'd0;
                    clk_pin_next      = 1'b0;
                    en_pin_next       = 1'b1;
                    if (frame_is_read_reg)
                    begin
                        captured_next = word_shift_next;
                        done_next     = 1'b1;
                    end
                end
                else
                begin
                    phase_next  = phase_inc;
                    apply_phase = phase_inc;
                    apply       = 1'b1;
                end
            end
        end
        new_ph = describe(frame_is_read_next, apply_phase, address_shift_next,
                          word_shift_next);
        if (apply)
        begin
            dat_pin_next    = new_ph.set_data ? new_ph.data : dat_pin_reg;
            clk_pin_next    = new_ph.clk;
            drv_pin_next    = new_ph.drv;
            en_pin_next     = new_ph.en;
            hold_count_next = new_ph.hold;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_active_reg  <= 1'b0;
            frame_is_read_reg <= 1'b0;
            phase_reg         <= '0;
            hold_count_reg    <= 2'd0;
            address_shift_reg <= '0;
            word_shift_reg    <= '0;
            captured_reg      <= '0;
            clk_pin_reg       <= 1'b0;
            dat_pin_reg       <= 1'b0;
            drv_pin_reg       <= 1'b1;
            en_pin_reg        <= 1'b1;
            done_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else if (fire)
        begin
            // pin registers double as the result register
            frame_active_reg  <= frame_active_next;
            frame_is_read_reg <= frame_is_read_next;
            phase_reg         <= phase_next;
            hold_count_reg    <= hold_count_next;
            address_shift_reg <= address_shift_next;
            word_shift_reg    <= word_shift_next;
            captured_reg      <= captured_next;
            clk_pin_reg       <= clk_pin_next;
            dat_pin_reg       <= dat_pin_next;
            drv_pin_reg       <= drv_pin_next;
            en_pin_reg        <= en_pin_next;
            done_reg          <= done_next;
            out_valid_reg     <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign clock_pin    = clk_pin_reg;
    assign data_pin_out = dat_pin_reg;
    assign data_drive   = drv_pin_reg;
    assign enable_pin   = en_pin_reg;
    assign busy_res     = frame_active_reg;
    assign read_word    = twrbm_pkg::WORD_W'(captured_reg);
    assign read_done    = done_reg;

    `TWRBM_ASSERT_IMP(a_idle_enable_high, clk, rst_n, !frame_active_reg, en_pin_reg)
    `TWRBM_ASSERT_NEVER(a_done_while_busy, clk, rst_n, done_reg && frame_active_reg)
    `TWRBM_ASSERT_IMP(a_hold_only_read_start, clk, rst_n, hold_count_reg != 2'd0,
        frame_active_reg && frame_is_read_reg && phase_reg == '0)

endmodule
`default_nettype wire
